>>> rtl/assert_macros.svh
// assertion helpers shared by the divider, datapath and controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/vln_pkg.sv
`default_nettype none
package vln_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 30;
    localparam int NORM_W    = 35;
    localparam int TOL_W     = 20;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [TOL_W-1:0]   TOL_RESET    = 20'd1074;
    localparam logic [NORM_W-1:0]  NORM_MAX     = {NORM_W{1'b1}};
    localparam logic [PADDR_W-1:0] REG_TOL_ADDR = 3'd0;

    // input beat: one vector component
    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last_element;
    } t_in_beat;

    // output beat: one norm result
    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic              converged;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHK,
        S_READ,
        S_EDIV,
        S_EWAIT,
        S_SQR,
        S_ACC,
        S_HINIT,
        S_HDIV,
        S_HWAIT,
        S_HTEST,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_idx;
        logic rd;
        logic ediv;
        logic sq;
        logic acc;
        logic hinit;
        logic hdiv;
        logic hupd;
        logic hfin;
        logic mul;
        logic sum;
        logic zero;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic max_zero;
        logic idx_end;
        logic div_busy;
        logic conv;
        logic iter_end;
        logic out_busy;
    } t_sts;

    // absolute value of a two's complement word, most negative gives 2^31
    function automatic logic [ELEM_W-1:0] mag_of(input logic [ELEM_W-1:0] bits);
        logic [ELEM_W-1:0] res;
        res = bits[ELEM_W-1] ? (~bits + 1'b1) : bits;
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/vln_regs.sv
`default_nettype none
module vln_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vln_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [vln_pkg::PDATA_W-1:0]   pwdata,
    output logic      [vln_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [vln_pkg::TOL_W-1:0]     o_tolerance
);
    import vln_pkg::*;

    logic [TOL_W-1:0] r_tol;

    // tolerance register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_TOL_ADDR)) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr == REG_TOL_ADDR) begin
            prdata = PDATA_W'(r_tol);
        end
    end

    assign pready      = 1'b1;
    assign o_tolerance = r_tol;

endmodule
`default_nettype wire

>>> rtl/vln_div.sv
`default_nettype none
`include "assert_macros.svh"
module vln_div #(
    parameter int DW = 63,
    parameter int BW = 37,
    parameter int QW = 38
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [BW-1:0] i_divisor,
    output logic      [QW-1:0] o_quotient,
    output logic               o_busy
);
    localparam int CNTW = $clog2(DW + 1);
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(DW - 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [BW-1:0]   r_rem;
    logic [BW-1:0]   r_dsr;
    logic [DW-1:0]   r_dvd;
    logic [QW-1:0]   r_quo;
    logic [BW:0]     trial;
    logic            ge;
    logic [BW-1:0]   n_rem;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_dvd[DW-1]};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? BW'(trial - {1'b0, r_dsr}) : trial[BW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    // shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dvd <= i_dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

    `ASSERT_CLK(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "divider started while busy")

endmodule
`default_nettype wire

>>> rtl/vln_dp.sv
`default_nettype none
`include "assert_macros.svh"
module vln_dp #(
    parameter int MAX_DIM  = 64,
    parameter int MAX_ITER = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire vln_pkg::t_cmd             i_cmd,
    output vln_pkg::t_sts                  o_sts,
    input  wire vln_pkg::t_in_beat         i_in_data,
    input  wire logic [vln_pkg::TOL_W-1:0] i_tolerance,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output vln_pkg::t_out_beat             o_out_data
);
    import vln_pkg::*;

    localparam int LG   = $clog2(MAX_DIM);
    localparam int AW   = (MAX_DIM > 1) ? LG : 1;
    localparam int CW   = $clog2(MAX_DIM + 1);
    localparam int SW   = 31 + LG;
    localparam int BW   = (SW > 33) ? SW : 33;
    localparam int DW   = BW + FRAC_BITS;
    localparam int QW   = BW + 1;
    localparam int IW   = $clog2(MAX_ITER + 1);
    localparam int TW   = BW + 3;
    localparam int SQW  = 2 * (FRAC_BITS + 1);

    logic [ELEM_W-1:0] mem [0:MAX_DIM-1];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [ELEM_W-1:0] r_max;
    logic [ELEM_W-1:0] r_rd;
    logic [SQW-1:0]    r_sq;
    logic [SW-1:0]     r_sum;
    logic [BW-1:0]     r_s;
    logic [IW-1:0]     r_iter;
    logic [63:0]       r_plo;
    logic [BW-1:0]     r_phi;
    logic [NORM_W-1:0] r_norm;
    logic              r_conv;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [ELEM_W-1:0] in_mag;
    logic              div_start;
    logic [DW-1:0]     div_dvd;
    logic [BW-1:0]     div_dsr;
    logic [QW-1:0]     quo;
    logic              div_busy;
    logic [QW-1:0]     s_ext;
    logic [QW-1:0]     diff;
    logic [QW:0]       s_plus_d;
    logic [TW-1:0]     total;

    assign in_mag = mag_of(i_in_data.element);

    // vector store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CW'(MAX_DIM))) begin
            mem[r_count[AW-1:0]] <= i_in_data.element;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    // element count, running maximum and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load && (r_count < CW'(MAX_DIM))) begin
                r_count <= r_count + 1'b1;
                if (in_mag > r_max) begin
                    r_max <= in_mag;
                end
            end
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_count <= '0;
                r_max   <= '0;
            end
        end
    end

    // shared divider operands
    always_comb begin
        div_start = i_cmd.ediv || i_cmd.hdiv;
        if (i_cmd.ediv) begin
            div_dvd = {BW'(mag_of(r_rd)), {FRAC_BITS{1'b0}}};
            div_dsr = BW'(r_max);
        end else begin
            div_dvd = {BW'(r_sum), {FRAC_BITS{1'b0}}};
            div_dsr = r_s;
        end
    end

    vln_div #(
        .DW(DW),
        .BW(BW),
        .QW(QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_quotient (quo),
        .o_busy     (div_busy)
    );

    // heron test and update terms, and the scale-back sum
    always_comb begin
        s_ext    = QW'(r_s);
        diff     = (s_ext >= quo) ? (s_ext - quo) : (quo - s_ext);
        s_plus_d = (QW + 1)'(s_ext) + (QW + 1)'(quo);
        total    = TW'({r_phi, 2'b00}) + TW'(r_plo[63:FRAC_BITS]);
    end

    // square, sum, root and scale back
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_sq <= quo[FRAC_BITS:0] * quo[FRAC_BITS:0];
        end
        if (i_cmd.clr_idx) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SW'(r_sq[SQW-1:FRAC_BITS]);
        end
        if (i_cmd.hinit) begin
            r_s    <= BW'(r_sum >> 1);
            r_iter <= '0;
        end else if (i_cmd.hupd) begin
            r_s    <= BW'(s_plus_d >> 1);
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.mul) begin
            r_plo <= r_s[31:0] * r_max;
            r_phi <= BW'(r_s[BW-1:32] * r_max);
        end
        if (i_cmd.zero) begin
            r_norm <= '0;
            r_conv <= 1'b1;
        end else begin
            if (i_cmd.hfin) begin
                r_conv <= (diff <= QW'(i_tolerance));
            end
            if (i_cmd.sum) begin
                r_norm <= (total > TW'(NORM_MAX)) ? NORM_MAX : total[NORM_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.norm      <= r_norm;
            r_out.converged <= r_conv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status
    always_comb begin
        o_sts.max_zero = (r_max == '0);
        o_sts.idx_end  = (r_idx == r_count);
        o_sts.div_busy = div_busy;
        o_sts.conv     = (diff <= QW'(i_tolerance));
        o_sts.iter_end = (r_iter == IW'(MAX_ITER));
        o_sts.out_busy = r_out_valid;
    end

    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= CW'(MAX_DIM), "element count beyond store")

endmodule
`default_nettype wire

>>> rtl/vln_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module vln_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_last,
    output logic               o_in_ready,
    input  wire vln_pkg::t_sts i_sts,
    output vln_pkg::t_cmd      o_cmd
);
    import vln_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (i_in_valid && i_last) n_state = S_CHK;
            S_CHK:   n_state = i_sts.max_zero ? S_OUT : S_READ;
            S_READ:  n_state = S_EDIV;
            S_EDIV:  n_state = S_EWAIT;
            S_EWAIT: if (!i_sts.div_busy) n_state = S_SQR;
            S_SQR:   n_state = S_ACC;
            S_ACC:   n_state = i_sts.idx_end ? S_HINIT : S_READ;
            S_HINIT: n_state = S_HDIV;
            S_HDIV:  n_state = S_HWAIT;
            S_HWAIT: if (!i_sts.div_busy) n_state = S_HTEST;
            S_HTEST: n_state = (i_sts.conv || i_sts.iter_end) ? S_MUL : S_HDIV;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   if (!i_sts.out_busy) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHK: begin
                o_cmd.clr_idx = 1'b1;
                o_cmd.zero    = i_sts.max_zero;
            end
            S_READ:  o_cmd.rd    = 1'b1;
            S_EDIV:  o_cmd.ediv  = 1'b1;
            S_EWAIT: o_cmd.sq    = 1'b0;
            S_SQR:   o_cmd.sq    = 1'b1;
            S_ACC:   o_cmd.acc   = 1'b1;
            S_HINIT: o_cmd.hinit = 1'b1;
            S_HDIV:  o_cmd.hdiv  = 1'b1;
            S_HWAIT: o_cmd.hdiv  = 1'b0;
            S_HTEST: begin
                if (i_sts.conv || i_sts.iter_end) begin
                    o_cmd.hfin = 1'b1;
                end else begin
                    o_cmd.hupd = 1'b1;
                end
            end
            S_MUL:   o_cmd.mul = 1'b1;
            S_SUM:   o_cmd.sum = 1'b1;
            S_OUT:   o_cmd.out_load = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

    `ASSERT_CLK(a_load_free, i_clk, i_rst_n, o_cmd.out_load |-> !i_sts.out_busy, "result overwritten")
    `ASSERT_NEVER(a_div_overlap, i_clk, i_rst_n, (o_cmd.ediv || o_cmd.hdiv) && i_sts.div_busy, "divider restarted")

endmodule
`default_nettype wire

>>> rtl/vector_l2_norm_scaled_unit.sv
// channel   direction  handshake                  beat
// in        input      i_in_valid / o_in_ready    vln_pkg::t_in_beat (element, last_element)
// out       output     o_out_valid / i_out_ready  vln_pkg::t_out_beat (norm, converged)
// cfg       input      apb psel/penable/pwrite    tolerance at byte address 0
//
// one element beat is taken per cycle while a vector loads; a result waiting at the output
// does not stop loading. after the last beat each stored element takes one division in the
// shared restoring divider (DW = max(31+log2(MAX_DIM),33)+30, 67 at defaults, its dividend
// width), and each heron step one more, up to MAX_ITER+1 divisions; an all-zero vector skips them.
// a held result stalls only the next vector's output step. synchronous active-low reset clears
// control, tolerance, element count, peak and read index; the store needs no clearing.
`default_nettype none
module vector_l2_norm_scaled_unit #(
    parameter int MAX_DIM  = 64,
    parameter int MAX_ITER = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire vln_pkg::t_in_beat             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output vln_pkg::t_out_beat                 o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vln_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [vln_pkg::PDATA_W-1:0]   pwdata,
    output logic      [vln_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import vln_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [TOL_W-1:0] tolerance;

    // configuration registers
    vln_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tolerance (tolerance)
    );

    // sequencer
    vln_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_data.last_element),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    vln_dp #(
        .MAX_DIM  (MAX_DIM),
        .MAX_ITER (MAX_ITER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_tolerance (tolerance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

>>> sim/vector_l2_norm_scaled_unit_chk.sv
`default_nettype none
module vector_l2_norm_scaled_unit_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire vln_pkg::t_in_beat           i_in_data,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire vln_pkg::t_out_beat          i_out_data,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic                        i_pready,
    input  wire logic [vln_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [vln_pkg::PDATA_W-1:0] i_pwdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import vln_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int ITER_CAP    = 16;
    localparam bit [63:0] WORD_ONES = 64'hFFFF_FFFF;

    bit [31:0]          comp_store[STORE_DEPTH];
    int                 comp_count;
    bit [63:0]          peak_mag;
    bit [TOL_W-1:0]     tol_reg;
    t_out_beat          norm_queue[$];

    function automatic bit [63:0] abs_of(bit [31:0] bits);
        return bits[31] ? ((64'(~bits) + 64'd1) & WORD_ONES) : 64'(bits);
    endfunction

    // floor(a * 2^30 / b), wrapping at 64 bits
    function automatic bit [63:0] q30_div(bit [63:0] a, bit [63:0] b);
        bit [63:0] q;
        bit [63:0] r;
        if (b == 0) return '1;
        q = a / b;
        r = a % b;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // scaled sum of squares, heron root, scale back by the peak
    function automatic t_out_beat predict_norm();
        t_out_beat res;
        bit [63:0] sum, s, d, diff, q, hp, lp;
        bit        conv;
        sum = 0;
        conv = 0;
        for (int i = 0; i < comp_count; i++) begin
            q = q30_div(abs_of(comp_store[i]), peak_mag);
            sum += (q * q) >> FRAC_BITS;
        end
        s = sum >> 1;
        for (int k = 0; k <= ITER_CAP; k++) begin
            d = q30_div(sum, s);
            diff = (s >= d) ? (s - d) : (d - s);
            if (diff <= 64'(tol_reg)) begin
                conv = 1;
                break;
            end
            if (k == ITER_CAP) break;
            s = (s >> 1) + (d >> 1) + (s & d & 64'd1);
        end
        hp = (s >> 32) * peak_mag;
        lp = ((s & WORD_ONES) * peak_mag) >> FRAC_BITS;
        if (hp > (64'(NORM_MAX) >> 2)) begin
            res.norm = NORM_MAX;
        end else if ((hp << 2) + lp > 64'(NORM_MAX)) begin
            res.norm = NORM_MAX;
        end else begin
            res.norm = NORM_W'((hp << 2) + lp);
        end
        res.converged = conv;
        return res;
    endfunction

    // track config writes, input beats and output beats
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            comp_count   = 0;
            peak_mag     = 0;
            tol_reg      <= TOL_RESET;
            o_fail_count <= 0;
            norm_queue.delete();
            o_pending    <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_TOL_ADDR) begin
                tol_reg <= i_pwdata[TOL_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                if (comp_count < STORE_DEPTH) begin
                    comp_store[comp_count] = i_in_data.element;
                    comp_count = comp_count + 1;
                    if (abs_of(i_in_data.element) > peak_mag) begin
                        peak_mag = abs_of(i_in_data.element);
                    end
                end
                if (i_in_data.last_element) begin
                    if (peak_mag == 0) begin
                        exp_beat.norm = '0;
                        exp_beat.converged = 1'b1;
                    end else begin
                        exp_beat = predict_norm();
                    end
                    norm_queue.push_back(exp_beat);
                    comp_count = 0;
                    peak_mag = 0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (norm_queue.size() == 0) begin
                    $display("%0t: unexpected result beat, actual norm=%0d converged=%0d",
                             $time, i_out_data.norm, i_out_data.converged);
                    errs = errs + 1;
                end else begin
                    exp_beat = norm_queue.pop_front();
                    if (exp_beat.norm !== i_out_data.norm) begin
                        $display("%0t: norm mismatch, expected %0d actual %0d",
                                 $time, exp_beat.norm, i_out_data.norm);
                        errs = errs + 1;
                    end
                    if (exp_beat.converged !== i_out_data.converged) begin
                        $display("%0t: converged mismatch, expected %0d actual %0d",
                                 $time, exp_beat.converged, i_out_data.converged);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= norm_queue.size();
        end
    end

endmodule
`default_nettype wire

>>> sim/vector_l2_norm_scaled_unit_tb.sv
`default_nettype none
module vector_l2_norm_scaled_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vln_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_beat             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_beat            out_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    bit                   quiet_in = 0;
    bit                   quiet_out = 0;
    int                   beats_sent = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    vector_l2_norm_scaled_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    vector_l2_norm_scaled_unit_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // one element beat, called and returning at a rising edge
    task automatic send_beat(logic [31:0] elem, logic last);
        int gap;
        gap = draw_gap(quiet_in);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data.element <= elem;
        in_data.last_element <= last;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // apb setup and access cycles
    task automatic write_tol(logic [TOL_W-1:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_TOL_ADDR;
        pwdata <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // let the block drain before touching the register
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_elem(int kind, logic [31:0] base);
        logic [31:0] v;
        case (kind)
            0: begin
                v = $urandom;
            end
            1: begin
                v = $urandom_range(0, 255) << $urandom_range(0, 16);
                if ($urandom_range(0, 1)) v = -v;
            end
            2: begin
                v = $urandom_range(0, 1) ? base : -base;
            end
            default: begin
                v = '0;
            end
        endcase
        return v;
    endfunction

    task automatic send_random_vector();
        int          len;
        int          kind;
        int          pick;
        logic [31:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 80) len = $urandom_range(1, 10);
        else if (pick < 97) len = $urandom_range(11, 64);
        else len = $urandom_range(65, 72);
        kind = $urandom_range(0, 9);
        base = $urandom;
        if (kind == 9) quiet_in = ~quiet_in;
        for (int i = 0; i < len; i++) begin
            if (kind == 8) send_beat(rand_elem(3, base), i == len - 1);
            else if (kind >= 6) send_beat(rand_elem($urandom_range(0, 3), base), i == len - 1);
            else if (kind >= 4) send_beat(rand_elem(2, base), i == len - 1);
            else if (kind >= 2) send_beat(rand_elem(1, base), i == len - 1);
            else send_beat(rand_elem(0, base), i == len - 1);
        end
    endtask

    // output side: random stalls, with quiet stretches
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) quiet_out = ~quiet_out;
            gap = draw_gap(quiet_out);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        logic [TOL_W-1:0] tol_list[5];
        tol_list[0] = TOL_RESET;
        tol_list[1] = 20'd1;
        tol_list[2] = 20'hFFFFF;
        tol_list[3] = TOL_W'($urandom_range(1, 20'hFFFFF));
        tol_list[4] = TOL_W'($urandom_range(1, 4096));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vectors, extremes, mixed signs
        write_tol(TOL_RESET);
        send_beat(32'd0, 1'b1);
        send_beat(32'd0, 1'b0);
        send_beat(32'd0, 1'b0);
        send_beat(32'd0, 1'b1);
        send_beat(32'h7FFF_FFFF, 1'b1);
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'd1, 1'b1);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'd1, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b0);
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'h0003_0000, 1'b0);
        send_beat(32'hFFFC_0000, 1'b1);
        send_beat(32'h0001_0000, 1'b0);
        send_beat(32'd0, 1'b0);
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'hAAAA_AAAA, 1'b1);

        // random phases across tolerance settings
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            write_tol(tol_list[(ph + 1) % 5]);
            while (beats_sent < 17 + (ph + 1) * 330) send_random_vector();
        end
        wait_idle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> vector_l2_norm_scaled_unit.f
+incdir+rtl
rtl/vln_pkg.sv
rtl/vln_regs.sv
rtl/vln_div.sv
rtl/vln_dp.sv
rtl/vln_ctrl.sv
rtl/vector_l2_norm_scaled_unit.sv
sim/vector_l2_norm_scaled_unit_chk.sv
sim/vector_l2_norm_scaled_unit_tb.sv
